FILE: hw/rtl/lphm_pkg.sv
// lphm_pkg: table size, hash constant, operation and status codes, item type
// shared by the hash map front end, queue and probe engine
// no dependencies
package lphm_pkg;

   // table geometry, slot count must be a power of two
   localparam int TABLE_SLOTS = 256;
   localparam int SLOT_BITS   = $clog2(TABLE_SLOTS);

   // multiplicative hash constant
   localparam logic [31:0] HASH_MULT = 32'h9e37_79b9;

   // depth of the queue between front end and probe engine
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

   // operation codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_INSERT = 1'b1;

   // result status codes
   localparam logic [1:0] STATUS_OK   = 2'd0;
   localparam logic [1:0] STATUS_MISS = 2'd1;
   localparam logic [1:0] STATUS_FULL = 2'd2;

   // classified item handed from front end to probe engine
   typedef struct packed {
      logic                 func;
      logic [31:0]          key;
      logic [31:0]          value;
      logic [SLOT_BITS-1:0] home;
   } lphm_item_type;

endpackage

FILE: hw/rtl/lphm_if.sv
// lphm_req_if and lphm_rsp_if: valid/ready channels for requests and results
// no dependencies
interface lphm_req_if;
   logic               valid;
   logic               ready;
   logic               func;
   logic signed [31:0] key;
   logic [31:0]        value;

   modport source (output valid, output func, output key, output value, input ready);
   modport sink   (input valid, input func, input key, input value, output ready);
endinterface

interface lphm_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] value_out;

   modport source (output valid, output status, output value_out, input ready);
   modport sink   (input valid, input status, input value_out, output ready);
endinterface

FILE: hw/rtl/lphm_front.sv
// lphm_front: accepts request items, computes the home slot, holds one item
// depends on lphm_pkg and lphm_req_if
module lphm_front
   import lphm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   lphm_req_if.sink      req,
   output logic          item_valid,
   input  logic          item_ready,
   output lphm_item_type item
);

   logic          valid_ff, valid_in;
   lphm_item_type item_ff, item_in;
   logic [31:0]   prod;
   logic          take;

   // multiplicative hash, low bits give the home slot
   assign prod = $unsigned(req.key) * HASH_MULT;

   // stage accepts when empty or draining into the queue
   assign req.ready = !valid_ff || item_ready;
   assign take      = req.valid && req.ready;

   always_comb begin
      valid_in = valid_ff;
      item_in  = item_ff;
      if (valid_ff && item_ready) begin
         valid_in = 1'b0;
      end
      if (take) begin
         valid_in      = 1'b1;
         item_in.func  = req.func;
         item_in.key   = $unsigned(req.key);
         item_in.value = req.value;
         item_in.home  = prod[SLOT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

FILE: hw/rtl/lphm_queue.sv
// lphm_queue: short fifo of classified items between front end and probe engine
// depends on lphm_pkg
module lphm_queue
   import lphm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          in_valid,
   output logic          in_ready,
   input  lphm_item_type in_item,
   output logic          out_valid,
   input  logic          out_ready,
   output lphm_item_type out_item
);

   lphm_item_type        entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_BITS-1:0] count_ff, count_in;
   logic                 push, pop;

   assign in_ready  = count_ff != QCNT_BITS'(QUEUE_DEPTH);
   assign out_valid = count_ff != '0;
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;
   assign out_item  = entry_ff[rd_ptr_ff];

   // pointer and count update with wraparound
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

FILE: hw/rtl/lphm_back.sv
// lphm_back: probe sequencer over the slot tables, writes inserts, drives results
// depends on lphm_pkg and lphm_rsp_if
module lphm_back
   import lphm_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          item_valid,
   output logic          item_ready,
   input  lphm_item_type item,
   lphm_rsp_if.source    rsp
);

   localparam logic ST_IDLE  = 1'b0;
   localparam logic ST_PROBE = 1'b1;

   // slot tables: used bits in flops, keys and values in memories
   logic [TABLE_SLOTS-1:0] used_ff, used_in;
   logic [31:0]            key_mem   [TABLE_SLOTS];
   logic [31:0]            value_mem [TABLE_SLOTS];

   logic                 state_ff, state_in;
   logic [SLOT_BITS-1:0] addr_ff, addr_in;
   logic [SLOT_BITS-1:0] tries_ff, tries_in;
   logic                 func_ff, func_in;
   logic [31:0]          key_ff, key_in;
   logic [31:0]          value_ff, value_in;
   logic [31:0]          rd_key_ff;
   logic [31:0]          rd_value_ff;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [1:0]           rsp_status_ff, rsp_status_in;
   logic [31:0]          rsp_value_ff, rsp_value_in;

   logic                 slot_used;
   logic                 slot_hit;
   logic                 last_try;
   logic                 wr_en;
   logic [SLOT_BITS-1:0] addr_next;

   assign slot_used = used_ff[addr_ff];
   assign slot_hit  = slot_used && (rd_key_ff == key_ff);
   assign last_try  = tries_ff == SLOT_BITS'(TABLE_SLOTS - 1);
   assign addr_next = (addr_ff == SLOT_BITS'(TABLE_SLOTS - 1)) ? '0 : addr_ff + 1'b1;

   // start only with the result register free
   assign item_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;

   // probe sequencer
   always_comb begin
      state_in      = state_ff;
      addr_in       = addr_ff;
      tries_in      = tries_ff;
      func_in       = func_ff;
      key_in        = key_ff;
      value_in      = value_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      used_in       = used_ff;
      wr_en         = 1'b0;

      if (rsp_valid_ff && rsp.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (item_valid && item_ready) begin
               func_in  = item.func;
               key_in   = item.key;
               value_in = item.value;
               addr_in  = item.home;
               tries_in = '0;
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (func_ff == FUNC_INSERT) begin
               if (!slot_used || slot_hit) begin
                  wr_en            = 1'b1;
                  used_in[addr_ff] = 1'b1;
                  rsp_valid_in     = 1'b1;
                  rsp_status_in    = STATUS_OK;
                  rsp_value_in     = '0;
                  state_in         = ST_IDLE;
               end else if (last_try) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_FULL;
                  rsp_value_in  = '0;
                  state_in      = ST_IDLE;
               end else begin
                  addr_in  = addr_next;
                  tries_in = tries_ff + 1'b1;
               end
            end else begin
               if (slot_hit) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_OK;
                  rsp_value_in  = rd_value_ff;
                  state_in      = ST_IDLE;
               end else if (!slot_used || last_try) begin
                  rsp_valid_in  = 1'b1;
                  rsp_status_in = STATUS_MISS;
                  rsp_value_in  = '0;
                  state_in      = ST_IDLE;
               end else begin
                  addr_in  = addr_next;
                  tries_in = tries_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         used_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         used_ff      <= used_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      addr_ff       <= addr_in;
      tries_ff      <= tries_in;
      func_ff       <= func_in;
      key_ff        <= key_in;
      value_ff      <= value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
   end

   // registered table read at the next probe address
   always_ff @(posedge clock) begin
      rd_key_ff   <= key_mem[addr_in];
      rd_value_ff <= value_mem[addr_in];
   end

   // table write on insert
   always_ff @(posedge clock) begin
      if (wr_en) begin
         key_mem[addr_ff]   <= key_ff;
         value_mem[addr_ff] <= value_ff;
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.status    = rsp_status_ff;
   assign rsp.value_out = rsp_value_ff;

endmodule

FILE: hw/rtl/linear_probe_hash_map.sv
// linear_probe_hash_map: open-addressing key/value table with linear probing
// path: front register, then the queue, then the probe sequencer, which probes one slot
// at a time (n = 1 to TABLE_SLOTS slots per item) and ends in the result register
// one item at a time in the probe sequencer: it starts the next item only when idle and
// once the result register has been taken
// reset: synchronous; clears all slot used bits at once, no clearing pass
module linear_probe_hash_map
   import lphm_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lphm_req_if.sink   req,
   lphm_rsp_if.source rsp
);

   logic          front_valid, front_ready;
   lphm_item_type front_item;
   logic          back_valid, back_ready;
   lphm_item_type back_item;

   // accept and hash
   lphm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .item_valid (front_valid),
      .item_ready (front_ready),
      .item       (front_item)
   );

   // decoupling queue
   lphm_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .in_item   (front_item),
      .out_valid (back_valid),
      .out_ready (back_ready),
      .out_item  (back_item)
   );

   // probe and result
   lphm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .item_valid (back_valid),
      .item_ready (back_ready),
      .item       (back_item),
      .rsp        (rsp)
   );

endmodule

FILE: tb/lphm_checker.sv
// lphm_checker: watches the request and result channels of the hash map,
// keeps its own slot table to predict each result and compares in order
// depends on lphm_pkg and the lphm_req_if / lphm_rsp_if interfaces
module lphm_checker
   import lphm_pkg::*;
(
   input  logic clock,
   input  logic reset,
   lphm_req_if  req,
   lphm_rsp_if  rsp,
   output int   fail_count,
   output int   pending
);

   typedef struct packed {
      logic [1:0]  status;
      logic [31:0] value_out;
   } lphm_result_type;

   // shadow copy of the table
   logic            slot_used  [TABLE_SLOTS];
   logic [31:0]     slot_key   [TABLE_SLOTS];
   logic [31:0]     slot_value [TABLE_SLOTS];
   lphm_result_type table_results_q [$];

   // walk the probe sequence from the home slot, updating the shadow table on insert
   function automatic lphm_result_type probe_table(input logic f, input logic [31:0] k,
                                                   input logic [31:0] v);
      logic [31:0]          prod;
      logic [SLOT_BITS-1:0] s;
      lphm_result_type      r;
      int                   n;
      prod        = k * HASH_MULT;
      s           = prod[SLOT_BITS-1:0];
      r.value_out = '0;
      r.status    = (f == FUNC_INSERT) ? STATUS_FULL : STATUS_MISS;
      for (n = 0; n < TABLE_SLOTS; n++) begin
         if (f == FUNC_LOOKUP) begin
            if (!slot_used[s])
               break;
            if (slot_key[s] == k) begin
               r.status    = STATUS_OK;
               r.value_out = slot_value[s];
               break;
            end
         end else if (!slot_used[s] || slot_key[s] == k) begin
            slot_used[s]  = 1'b1;
            slot_key[s]   = k;
            slot_value[s] = v;
            r.status      = STATUS_OK;
            break;
         end
         // slot count is a power of two, so the index wraps by itself
         s = s + 1'b1;
      end
      return r;
   endfunction

   // predict on each accepted request item, compare on each accepted result item
   always @(posedge clock) begin
      lphm_result_type want;
      if (reset) begin
         for (int i = 0; i < TABLE_SLOTS; i++)
            slot_used[i] = 1'b0;
         table_results_q.delete();
         fail_count = 0;
      end else begin
         if (rsp.valid && rsp.ready) begin
            if (table_results_q.size() == 0) begin
               $error("result item with nothing outstanding: status %0d value_out %h",
                      rsp.status, rsp.value_out);
               fail_count++;
            end else begin
               want = table_results_q.pop_front();
               if (rsp.status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp.status);
                  fail_count++;
               end
               if (rsp.value_out !== want.value_out) begin
                  $error("value_out: expected %h, actual %h", want.value_out, rsp.value_out);
                  fail_count++;
               end
            end
         end
         if (req.valid && req.ready)
            table_results_q.push_back(probe_table(req.func, req.key, req.value));
      end
      pending = table_results_q.size();
   end

endmodule

FILE: tb/tb.sv
// tb: stimulus and verdict for linear_probe_hash_map, directed then random items
// depends on lphm_pkg, lphm_req_if / lphm_rsp_if, the block and lphm_checker
module tb;
   import lphm_pkg::*;

   localparam int HOLD_CYCLES = 300;
   localparam int TAIL_CYCLES = TABLE_SLOTS + 64;
   localparam int RUN_LIMIT   = 20_000_000;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending;
   bit   sender_gaps;
   bit   receiver_gaps;
   bit   hold_rsp;

   logic [31:0] key_pool [$];

   lphm_req_if req ();
   lphm_rsp_if rsp ();

   linear_probe_hash_map DUT (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .rsp   (rsp)
   );

   lphm_checker table_monitor (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .rsp        (rsp),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // run limit
   initial begin
      #RUN_LIMIT;
      $display("CHECKS FAILED");
      $finish;
   end

   // offer one item, with optional idle cycles first, and wait until it is taken
   task automatic send_item(input logic f, input logic [31:0] k, input logic [31:0] v);
      while (sender_gaps && $urandom_range(0, 99) < 20) begin
         req.valid <= 1'b0;
         @(posedge clock);
      end
      req.valid <= 1'b1;
      req.func  <= f;
      req.key   <= k;
      req.value <= v;
      do @(posedge clock); while (!req.ready);
   endtask

   // grow the key pool, a third of the keys with low byte 0x77 to 0x7a (0x77 homes to the last slot)
   task automatic add_keys(input int count);
      logic [31:0] k;
      for (int i = 0; i < count; i++) begin
         k = $urandom();
         if ($urandom_range(0, 2) == 0)
            k[7:0] = 8'h77 + 8'($urandom_range(0, 3));
         key_pool.push_back(k);
      end
   endtask

   // mostly pool keys so lookups hit and inserts overwrite, the rest fresh keys
   task automatic play_random(input int count, input int noise_pct);
      logic        f;
      logic [31:0] k;
      for (int i = 0; i < count; i++) begin
         f = ($urandom_range(0, 99) < 45) ? FUNC_INSERT : FUNC_LOOKUP;
         if ($urandom_range(0, 99) < noise_pct)
            k = $urandom();
         else
            k = key_pool[$urandom_range(0, key_pool.size() - 1)];
         send_item(f, k, $urandom());
      end
   endtask

   // result side: random stalls, or one long hold-off on request
   initial begin
      rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp.ready <= !(receiver_gaps && $urandom_range(0, 99) < 20);
         end
      end
   end

   // main sequence
   initial begin
      reset         <= 1'b1;
      req.valid     <= 1'b0;
      req.func      <= FUNC_LOOKUP;
      req.key       <= '0;
      req.value     <= '0;
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      hold_rsp      = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // empty table miss, insert, overwrite, extreme keys and values
      send_item(FUNC_LOOKUP, 32'h0000_0000, 32'hffff_ffff);
      send_item(FUNC_INSERT, 32'h0000_0000, 32'hffff_ffff);
      send_item(FUNC_LOOKUP, 32'h0000_0000, 32'h0000_0000);
      send_item(FUNC_INSERT, 32'h0000_0000, 32'h0000_0000);
      send_item(FUNC_LOOKUP, 32'h0000_0000, 32'h5555_5555);
      send_item(FUNC_INSERT, 32'h7fff_ffff, 32'h1234_5678);
      send_item(FUNC_INSERT, 32'h8000_0000, 32'hffff_ffff);
      send_item(FUNC_INSERT, 32'hffff_ffff, 32'h8000_0001);
      send_item(FUNC_LOOKUP, 32'h7fff_ffff, 32'haaaa_aaaa);
      send_item(FUNC_LOOKUP, 32'h8000_0000, 32'h0000_0000);
      send_item(FUNC_LOOKUP, 32'hffff_ffff, 32'hffff_ffff);
      // low byte 0x77 homes to the last slot, so this chain wraps to slot 0
      send_item(FUNC_INSERT, 32'h0000_0077, $urandom());
      send_item(FUNC_INSERT, 32'h0000_0177, $urandom());
      send_item(FUNC_INSERT, 32'h8000_0077, $urandom());
      send_item(FUNC_LOOKUP, 32'h8000_0077, $urandom());
      send_item(FUNC_LOOKUP, 32'h0000_0277, $urandom());
      send_item(FUNC_LOOKUP, 32'hffff_ff77, $urandom());

      // sender waits for the table to drain
      req.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);

      // partly loaded table: long result hold-off and a stretch with no idling
      add_keys(150);
      sender_gaps   = 1'b0;
      receiver_gaps = 1'b0;
      hold_rsp      = 1'b1;
      play_random(350, 15);
      sender_gaps   = 1'b1;
      receiver_gaps = 1'b1;
      play_random(550, 15);

      req.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);

      // more keys than slots: table fills, inserts fail, misses probe everything
      add_keys(150);
      play_random(1000, 10);

      req.valid <= 1'b0;
      @(posedge clock);
      wait (pending == 0);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule

FILE: linear_probe_hash_map.f
hw/rtl/lphm_pkg.sv
hw/rtl/lphm_if.sv
hw/rtl/lphm_front.sv
hw/rtl/lphm_queue.sv
hw/rtl/lphm_back.sv
hw/rtl/linear_probe_hash_map.sv
tb/lphm_checker.sv
tb/tb.sv
